/* rtl/core/bss_pkg.sv */
// Shared types, widths and constants for the six-sensor bearing and steering block.
// Holds the CORDIC arctangent table and the item payload structs used between stages.
// No dependencies.
`timescale 1ns / 1ps

package bss_pkg;

  // Vector components after weighting, Q10, magnitude below 2^20.
  localparam int XW = 21;
  // CORDIC x/y datapath width: |x|,|y| scaled by 256 and grown by the CORDIC gain.
  localparam int CW = 31;
  // Angle accumulator width, degrees in Q16.
  localparam int ZW = 26;
  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam int DEG_W = 9;

  localparam logic signed [ZW-1:0] Z_90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);

  // Register reset values.
  localparam logic [7:0] THRESHOLD_RESET = 8'd20;
  localparam logic [7:0] WINDOW_RESET    = 8'd9;

  // Register indexes on the configuration port.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  typedef logic [1:0] led_mode_t;
  localparam led_mode_t LED_OFF   = 2'd0;
  localparam led_mode_t LED_GREEN = 2'd1;
  localparam led_mode_t LED_BLUE  = 2'd2;

  // Per-item data that rides alongside the CORDIC chain.
  typedef struct packed {
    logic             special;
    logic [7:0]       spec_mag;
    logic             xneg;
    logic             yneg;
    led_mode_t [5:0]  led;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cordic_t;

  // atan(2^-i) in degrees, Q16, rounded.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      4'd0:  r = ZW'(2949120);
      4'd1:  r = ZW'(1740967);
      4'd2:  r = ZW'(919879);
      4'd3:  r = ZW'(466945);
      4'd4:  r = ZW'(234379);
      4'd5:  r = ZW'(117304);
      4'd6:  r = ZW'(58666);
      4'd7:  r = ZW'(29335);
      4'd8:  r = ZW'(14668);
      4'd9:  r = ZW'(7334);
      4'd10: r = ZW'(3667);
      4'd11: r = ZW'(1833);
      4'd12: r = ZW'(917);
      4'd13: r = ZW'(458);
      4'd14: r = ZW'(229);
      4'd15: r = ZW'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/bss_front.sv */
// Front stage: intensity thresholding, weighted x/y vector and LED modes.
// Presents the prepared CORDIC start vector and side data. Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            threshold,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [5:0][7:0]       ir,
  input  logic [5:0][7:0]       id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bss_pkg::cordic_t      out_data
);
  import bss_pkg::*;

  logic [5:0][7:0]      v;
  led_mode_t [5:0]      led_next;
  logic signed [10:0]   sx;
  logic signed [10:0]   sh;
  logic signed [10:0]   sy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;

  logic                 valid;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  led_mode_t [5:0]      led;

  logic [XW-1:0]        absx;
  logic [XW-1:0]        absy;

  // Suppress weak intensities and pick the LED mode from the raw values.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      v[i] = (ir[i] < threshold) ? 8'd0 : ir[i];
      if (ir[i] == 8'd0) begin
        led_next[i] = LED_OFF;
      end else if (id[i] == 8'd0) begin
        led_next[i] = LED_GREEN;
      end else begin
        led_next[i] = LED_BLUE;
      end
    end
  end

  // Weighted sums: a,d carry x weight 1; b,c,e,f carry x weight 0.5 and y weight 0.866.
  always_comb begin
    sx = $signed({3'b0, v[3]}) - $signed({3'b0, v[0]});
    sh = $signed({3'b0, v[2]}) + $signed({3'b0, v[4]})
       - $signed({3'b0, v[1]}) - $signed({3'b0, v[5]});
    sy = $signed({3'b0, v[4]}) + $signed({3'b0, v[5]})
       - $signed({3'b0, v[1]}) - $signed({3'b0, v[2]});
    x_next = (XW'(sx) <<< 10) + (XW'(sh) <<< 9);
    y_next = XW'(sy) * XW'(887);
  end

  assign in_stall = valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      x   <= x_next;
      y   <= y_next;
      led <= led_next;
    end
  end

  // Start vector for the CORDIC chain: magnitudes scaled by 256, axis cases flagged.
  always_comb begin
    absx = x[XW-1] ? XW'(-x) : XW'(x);
    absy = y[XW-1] ? XW'(-y) : XW'(y);
    out_data.cx = CW'({absx, 8'b0});
    out_data.cy = CW'({absy, 8'b0});
    out_data.z  = '0;
    out_data.side.xneg = x[XW-1];
    out_data.side.yneg = y[XW-1];
    out_data.side.led  = led;
    if (y == '0) begin
      out_data.side.special  = 1'b1;
      out_data.side.spec_mag = x[XW-1] ? 8'd180 : 8'd0;
    end else if (x == '0) begin
      out_data.side.special  = 1'b1;
      out_data.side.spec_mag = 8'd90;
    end else begin
      out_data.side.special  = 1'b0;
      out_data.side.spec_mag = 8'd0;
    end
  end

  assign out_valid = valid;

endmodule

/* rtl/core/bss_cordic_cell.sv */
// One vectoring CORDIC iteration with its own pipeline register.
// STEP selects the shift and the arctangent constant. Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bss_pkg::cordic_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bss_pkg::cordic_t  out_data
);
  import bss_pkg::*;

  localparam logic signed [CW-1:0] RND = CW'((longint'(1) << STEP) - longint'(1));

  logic             valid;
  cordic_t          data;
  cordic_t          data_next;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  // Divide by 2^STEP, truncating toward zero.
  function automatic logic signed [CW-1:0] shr0(input logic signed [CW-1:0] a);
    logic signed [CW-1:0] b;
    b = a + (a[CW-1] ? RND : '0);
    return b >>> STEP;
  endfunction

  // Rotate toward the x axis; the direction follows the sign of y.
  always_comb begin
    dx = shr0(in_data.cx);
    dy = shr0(in_data.cy);
    data_next.side = in_data.side;
    if (!in_data.cy[CW-1] && in_data.cy != '0) begin
      data_next.cx = in_data.cx + dy;
      data_next.cy = in_data.cy - dx;
      data_next.z  = in_data.z + atan_q16(4'(STEP));
    end else begin
      data_next.cx = in_data.cx - dy;
      data_next.cy = in_data.cy + dx;
      data_next.z  = in_data.z - atan_q16(4'(STEP));
    end
  end

  assign in_stall = valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* rtl/core/bss_back.sv */
// Back end: angle clamp, quadrant mirror, whole degrees, sign and steering decision.
// Two pipeline registers; the second one is the output register. Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               window,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  bss_pkg::cordic_t         in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [8:0]        bearing_deg,
  output logic                     go_forward,
  output bss_pkg::led_mode_t [5:0] led_mode
);
  import bss_pkg::*;

  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zm;

  // Stage one registers.
  logic                 pvalid;
  logic                 pstall;
  logic [7:0]           pdeg;
  side_t                pside;

  // Stage two (output) registers.
  logic                 ovalid;
  logic                 ostall;
  logic [7:0]           mag;
  logic signed [8:0]    bearing;
  logic                 go;
  led_mode_t [5:0]      led;

  logic [7:0]           mag_next;

  // Clamp to [0, 90] degrees, mirror for negative x, keep whole degrees.
  always_comb begin
    if (in_data.z[ZW-1]) begin
      zc = '0;
    end else if (in_data.z > Z_90) begin
      zc = Z_90;
    end else begin
      zc = in_data.z;
    end
    zm = in_data.side.xneg ? (Z_180 - zc) : zc;
  end

  assign ostall   = ovalid && out_stall;
  assign pstall   = pvalid && ostall;
  assign in_stall = pstall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (!pstall) begin
        pvalid <= in_valid;
      end
      if (!ostall) begin
        ovalid <= pvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!pstall && in_valid) begin
      pdeg  <= zm[FRAC+7:FRAC];
      pside <= in_data.side;
    end
  end

  // Apply the sign of y and compare the magnitude with the forward window.
  assign mag_next = pside.special ? pside.spec_mag : pdeg;

  always_ff @(posedge clk) begin
    if (!ostall && pvalid) begin
      mag     <= mag_next;
      bearing <= pside.yneg ? -$signed({1'b0, mag_next}) : $signed({1'b0, mag_next});
      go      <= (mag_next < window);
      led     <= pside.led;
    end
  end

  assign out_valid   = ovalid;
  assign bearing_deg = bearing;
  assign go_forward  = go;
  assign led_mode    = led;

`ifndef NO_ASSERTIONS
  // The magnitude register and the signed bearing agree.
  a_mag_matches: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (bearing == $signed({1'b0, mag}) || bearing == -$signed({1'b0, mag})))
    else $error("bearing and magnitude disagree");
  // A held output keeps the stage behind it from overwriting a waiting item.
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (ovalid && out_stall && pvalid) |=> (pvalid && $stable(pdeg)))
    else $error("stage one item lost while output stalled");
  // Angle magnitude never exceeds a half turn.
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (mag <= 8'd180))
    else $error("bearing magnitude out of range");
`endif

endmodule

/* rtl/core/six_sensor_bearing_steer.sv */
// Top level of the six-sensor bearing and steering block.
// Instantiates bss_front, the bss_cordic_cell chain and bss_back. Depends on bss_pkg.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one sensor frame per item: six
//   intensities ir_a..ir_f and six neighbor IDs id_a..id_f. The output channel
//   (out_valid / out_stall) returns one result item per frame, in order: bearing_deg,
//   go_forward and led_mode_a..led_mode_f.
//   The item passes nineteen registers: one front stage, sixteen CORDIC cells (one
//   iteration each) and two back stages. The first loads at the accepting edge.
//   Throughput is one item per cycle while the receiver does not stall, set by the
//   CORDIC cell chain, where every cell takes a new vector each cycle that it is
//   not stalled.
//   When the receiver stalls, the result holds on the outputs. Each stage behind it
//   still advances into empty slots, so in_stall only rises once every stage holds
//   an item.
//   Reset empties the pipeline and sets intensity_threshold to 20 and
//   forward_window to 9. Registers sit at byte addresses 0 and 4 of the APB port
//   and are to be written only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module six_sensor_bearing_steer (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ir_a,
  input  logic [7:0]         ir_b,
  input  logic [7:0]         ir_c,
  input  logic [7:0]         ir_d,
  input  logic [7:0]         ir_e,
  input  logic [7:0]         ir_f,
  input  logic [7:0]         id_a,
  input  logic [7:0]         id_b,
  input  logic [7:0]         id_c,
  input  logic [7:0]         id_d,
  input  logic [7:0]         id_e,
  input  logic [7:0]         id_f,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  bearing_deg,
  output logic               go_forward,
  output bss_pkg::led_mode_t led_mode_a,
  output bss_pkg::led_mode_t led_mode_b,
  output bss_pkg::led_mode_t led_mode_c,
  output bss_pkg::led_mode_t led_mode_d,
  output bss_pkg::led_mode_t led_mode_e,
  output bss_pkg::led_mode_t led_mode_f
);
  import bss_pkg::*;

  logic [7:0]      threshold;
  logic [7:0]      window;
  logic            cfg_write;

  logic [5:0][7:0] ir;
  logic [5:0][7:0] id;
  led_mode_t [5:0] led_mode;

  // Chain links: index 0 is the front stage output, index STEPS the last cell output.
  logic            link_valid [STEPS+1];
  logic            link_stall [STEPS+1];
  cordic_t         link_data  [STEPS+1];

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      window    <= WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: threshold <= pwdata[7:0];
        REG_WINDOW:    window    <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {24'b0, threshold};
      REG_WINDOW:    prdata = {24'b0, window};
      default:       prdata = '0;
    endcase
  end

  assign ir = {ir_f, ir_e, ir_d, ir_c, ir_b, ir_a};
  assign id = {id_f, id_e, id_d, id_c, id_b, id_a};

  bss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ir        (ir),
    .id        (id),
    .out_valid (link_valid[0]),
    .out_stall (link_stall[0]),
    .out_data  (link_data[0])
  );

  // Row of CORDIC cells, one iteration per cell.
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    bss_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_stall  (link_stall[g]),
      .in_data   (link_data[g]),
      .out_valid (link_valid[g+1]),
      .out_stall (link_stall[g+1]),
      .out_data  (link_data[g+1])
    );
  end

  bss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .window      (window),
    .in_valid    (link_valid[STEPS]),
    .in_stall    (link_stall[STEPS]),
    .in_data     (link_data[STEPS]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bearing_deg (bearing_deg),
    .go_forward  (go_forward),
    .led_mode    (led_mode)
  );

  assign led_mode_a = led_mode[0];
  assign led_mode_b = led_mode[1];
  assign led_mode_c = led_mode[2];
  assign led_mode_d = led_mode[3];
  assign led_mode_e = led_mode[4];
  assign led_mode_f = led_mode[5];

`ifndef NO_ASSERTIONS
  // The input side only stalls when a result is held at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");
  // Forward is only flagged for a bearing strictly inside the window.
  a_forward_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && go_forward) |->
      ($signed(bearing_deg) < $signed({2'b0, window}) &&
       $signed(bearing_deg) > -$signed({2'b0, window})))
    else $error("go_forward outside the forward window");
  // A threshold write lands in the register.
  a_threshold_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[2] == REG_THRESHOLD) |=> (threshold == $past(pwdata[7:0])))
    else $error("threshold write lost");
  // Bearing stays within a half turn either way.
  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing_deg >= -9'sd180 && bearing_deg <= 9'sd180))
    else $error("bearing out of range");
`endif

endmodule

/* tb/sv/six_sensor_bearing_steer_tb.sv */
// Self-checking testbench for six_sensor_bearing_steer: directed and random sensor frames.
// Predicts bearing, steering flag and LED modes with its own CORDIC model; uses bss_pkg.
// Drives the APB register port between phases and checks every result in order.
`timescale 1ns / 1ps

module six_sensor_bearing_steer_tb;

  import bss_pkg::*;

  // One sensor frame; index 0 is channel a, index 5 is channel f.
  typedef struct packed {
    logic [0:5][7:0] ir;
    logic [0:5][7:0] id;
  } frame_t;

  // One steering result as the block should return it.
  typedef struct packed {
    logic signed [8:0] bearing;
    logic              fwd;
    led_mode_t [0:5]   led;
  } steer_t;

  localparam logic [2:0] ADDR_THRESHOLD = 3'(4 * REG_THRESHOLD);
  localparam logic [2:0] ADDR_WINDOW    = 3'(4 * REG_WINDOW);
  localparam int PIPE_LATENCY   = 19;
  localparam int HOLD_LEN       = 160;
  localparam int WATCHDOG_LIMIT = 4000;

  // atan(2^-i) in degrees, Q16.
  localparam longint ATAN_Q16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ir_a = '0, ir_b = '0, ir_c = '0, ir_d = '0, ir_e = '0, ir_f = '0;
  logic [7:0]  id_a = '0, id_b = '0, id_c = '0, id_d = '0, id_e = '0, id_f = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [8:0] bearing_deg;
  logic        go_forward;
  led_mode_t   led_mode_a, led_mode_b, led_mode_c, led_mode_d, led_mode_e, led_mode_f;

  // Predictor copy of the two registers.
  logic [7:0] thr_q = THRESHOLD_RESET;
  logic [7:0] win_q = WINDOW_RESET;

  frame_t frame_q[$];
  steer_t steer_q[$];
  frame_t frame_on_bus;

  int errors = 0;
  int in_count = 0;
  int send_gap = 0;
  int drv_quiet = 0;
  int stall_left = 0;
  int mon_quiet = 0;
  int hold_cnt = 0;
  int next_hold_at = 100;
  int idle_cycles = 0;

  six_sensor_bearing_steer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .ir_a(ir_a), .ir_b(ir_b), .ir_c(ir_c), .ir_d(ir_d), .ir_e(ir_e), .ir_f(ir_f),
    .id_a(id_a), .id_b(id_b), .id_c(id_c), .id_d(id_d), .id_e(id_e), .id_f(id_f),
    .out_valid(out_valid), .out_stall(out_stall),
    .bearing_deg(bearing_deg), .go_forward(go_forward),
    .led_mode_a(led_mode_a), .led_mode_b(led_mode_b), .led_mode_c(led_mode_c),
    .led_mode_d(led_mode_d), .led_mode_e(led_mode_e), .led_mode_f(led_mode_f)
  );

  // Clock with a 2 ns period.
  always #1 clk = ~clk;

  // Bearing in whole degrees from a Q10 vector, by 16-step vectoring CORDIC.
  function automatic int bearing_of_vector(longint x, longint y);
    longint cx, cy, z, dx, dy;
    int i, deg;
    if (y == 0) return (x < 0) ? 180 : 0;
    if (x == 0) return (y > 0) ? 90 : -90;
    cx = ((x < 0) ? -x : x) * 256;
    cy = ((y < 0) ? -y : y) * 256;
    z = 0;
    for (i = 0; i < 16; i++) begin
      dx = cx / (longint'(1) << i);
      dy = cy / (longint'(1) << i);
      if (cy > 0) begin
        cx = cx + dy;
        cy = cy - dx;
        z = z + ATAN_Q16[i];
      end else begin
        cx = cx - dy;
        cy = cy + dx;
        z = z - ATAN_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    if (x < 0) z = 180 * 65536 - z;
    deg = int'(z / 65536);
    return (y < 0) ? -deg : deg;
  endfunction

  // Expected steering result for one frame under the current registers.
  function automatic steer_t predict_steer(frame_t f);
    longint v [6];
    longint x, y;
    int b, mag, k;
    steer_t r;
    for (k = 0; k < 6; k++) begin
      v[k] = (f.ir[k] < thr_q) ? 64'sd0 : longint'(f.ir[k]);
    end
    x = 1024 * (v[3] - v[0]) + 512 * (v[2] + v[4] - v[1] - v[5]);
    y = 887 * (v[4] + v[5] - v[1] - v[2]);
    b = bearing_of_vector(x, y);
    mag = (b < 0) ? -b : b;
    r.bearing = 9'(b);
    r.fwd = (mag < int'(win_q));
    for (k = 0; k < 6; k++) begin
      if (f.ir[k] == 8'd0) r.led[k] = LED_OFF;
      else if (f.id[k] == 8'd0) r.led[k] = LED_GREEN;
      else r.led[k] = LED_BLUE;
    end
    return r;
  endfunction

  // Random idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Intensity biased toward zero, the threshold edge and full scale.
  function automatic logic [7:0] rand_ir();
    int r, t;
    r = $urandom_range(0, 99);
    t = int'(thr_q) + $urandom_range(0, 2) - 1;
    if (r < 18) return 8'd0;
    if (r < 33) return (t < 0) ? 8'd0 : ((t > 255) ? 8'd255 : 8'(t));
    if (r < 43) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_id();
    return ($urandom_range(0, 99) < 40) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic add_frame(logic [0:5][7:0] irs, logic [0:5][7:0] ids);
    frame_t f;
    f.ir = irs;
    f.id = ids;
    frame_q.push_back(f);
  endtask

  task automatic add_random(int n);
    frame_t f;
    int j, k;
    for (j = 0; j < n; j++) begin
      for (k = 0; k < 6; k++) begin
        f.ir[k] = rand_ir();
        f.id[k] = rand_id();
      end
      frame_q.push_back(f);
    end
  endtask

  // APB write with random upper data bits; only the low byte is meaningful.
  task automatic apb_write(logic [2:0] addr, logic [7:0] value);
    logic [31:0] word;
    word = $urandom();
    word[7:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // APB read, checking the low byte against what was written.
  task automatic apb_check(logic [2:0] addr, logic [7:0] want, string name);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== want) report_mismatch(name, int'(prdata[7:0]), int'(want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(logic [7:0] thr, logic [7:0] win);
    apb_write(ADDR_THRESHOLD, thr);
    apb_write(ADDR_WINDOW, win);
    thr_q = thr;
    win_q = win;
    apb_check(ADDR_THRESHOLD, thr, "threshold readback");
    apb_check(ADDR_WINDOW, win, "window readback");
  endtask

  // Wait until every frame is sent and every result has come back.
  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || steer_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 6) @(posedge clk);
  endtask

  // Sender: offers frames from the queue with random gaps and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        steer_q.push_back(predict_steer(frame_on_bus));
        in_count <= in_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (frame_q.size() > 0) begin
          frame_on_bus = frame_q.pop_front();
          in_valid <= 1'b1;
          ir_a <= frame_on_bus.ir[0];
          ir_b <= frame_on_bus.ir[1];
          ir_c <= frame_on_bus.ir[2];
          ir_d <= frame_on_bus.ir[3];
          ir_e <= frame_on_bus.ir[4];
          ir_f <= frame_on_bus.ir[5];
          id_a <= frame_on_bus.id[0];
          id_b <= frame_on_bus.id[1];
          id_c <= frame_on_bus.id[2];
          id_d <= frame_on_bus.id[3];
          id_e <= frame_on_bus.id[4];
          id_f <= frame_on_bus.id[5];
          if (drv_quiet > 0) begin
            drv_quiet <= drv_quiet - 1;
            send_gap <= 0;
          end else if ($urandom_range(0, 63) == 0) begin
            drv_quiet <= $urandom_range(40, 150);
            send_gap <= 0;
          end else begin
            send_gap <= idle_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs at a few points so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (in_count >= next_hold_at) begin
      hold_cnt <= HOLD_LEN;
      next_hold_at <= next_hold_at + 600;
    end
  end

  // Receiver: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (steer_q.size() == 0) begin
          report_mismatch("result with nothing expected, bearing", int'(bearing_deg), 0);
        end else begin
          if (bearing_deg !== steer_q[0].bearing)
            report_mismatch("bearing_deg", int'(bearing_deg), int'(steer_q[0].bearing));
          if (go_forward !== steer_q[0].fwd)
            report_mismatch("go_forward", int'(go_forward), int'(steer_q[0].fwd));
          if (led_mode_a !== steer_q[0].led[0])
            report_mismatch("led_mode_a", int'(led_mode_a), int'(steer_q[0].led[0]));
          if (led_mode_b !== steer_q[0].led[1])
            report_mismatch("led_mode_b", int'(led_mode_b), int'(steer_q[0].led[1]));
          if (led_mode_c !== steer_q[0].led[2])
            report_mismatch("led_mode_c", int'(led_mode_c), int'(steer_q[0].led[2]));
          if (led_mode_d !== steer_q[0].led[3])
            report_mismatch("led_mode_d", int'(led_mode_d), int'(steer_q[0].led[3]));
          if (led_mode_e !== steer_q[0].led[4])
            report_mismatch("led_mode_e", int'(led_mode_e), int'(steer_q[0].led[4]));
          if (led_mode_f !== steer_q[0].led[5])
            report_mismatch("led_mode_f", int'(led_mode_f), int'(steer_q[0].led[5]));
          void'(steer_q.pop_front());
        end
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (mon_quiet > 0) begin
        out_stall <= 1'b0;
        mon_quiet <= mon_quiet - 1;
      end else if ($urandom_range(0, 63) == 0) begin
        out_stall <= 1'b0;
        mon_quiet <= $urandom_range(40, 150);
      end else begin
        stall_left <= idle_len();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Phases: reset defaults with directed frames, then register extremes and random settings.
  initial begin
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset registers.
    add_frame(48'h00_00_00_00_00_00, 48'h00_00_00_00_00_00);
    add_frame(48'hFF_FF_FF_FF_FF_FF, 48'hFF_FF_FF_FF_FF_FF);
    add_frame(48'hFF_FF_FF_FF_FF_FF, 48'h00_00_00_00_00_00);
    // Vector on the negative x axis, then each single sensor alone.
    add_frame(48'hFF_00_00_00_00_00, 48'h01_00_00_00_00_00);
    add_frame(48'h00_00_00_FF_00_00, 48'h00_00_00_80_00_00);
    add_frame(48'h00_FF_00_00_00_00, 48'h00_00_00_00_00_00);
    add_frame(48'h00_00_FF_00_00_00, 48'h00_00_7F_00_00_00);
    add_frame(48'h00_00_00_00_FF_00, 48'h00_00_00_00_00_00);
    add_frame(48'h00_00_00_00_00_FF, 48'h00_00_00_00_00_FE);
    // Vector on the y axis, both signs.
    add_frame(48'h00_00_00_00_64_64, 48'h00_00_00_00_00_00);
    add_frame(48'h00_64_64_00_00_00, 48'h00_00_00_00_00_00);
    // Just below and at the threshold.
    add_frame(48'h00_00_00_13_00_00, 48'h00_00_00_01_00_00);
    add_frame(48'h00_00_00_14_00_00, 48'h00_00_00_01_00_00);
    // Small angles around the forward window and near +-180.
    add_frame(48'h00_00_00_C8_28_00, 48'h00_00_00_00_00_00);
    add_frame(48'h00_00_3C_FF_00_00, 48'h00_00_00_00_00_00);
    add_frame(48'h00_00_00_FF_15_00, 48'h00_00_00_00_00_00);
    add_frame(48'hFF_00_00_00_00_28, 48'h00_00_00_00_00_00);
    add_frame(48'hFF_28_00_00_00_00, 48'h00_00_00_00_00_00);
    add_frame(48'h00_00_00_FF_FF_00, 48'h55_AA_00_00_00_00);
    add_frame(48'h01_02_80_FE_FF_7F, 48'h00_FF_01_80_00_7F);
    add_frame(48'hAA_55_AA_55_AA_55, 48'h55_AA_55_AA_55_AA);
    add_random(200);
    wait_drained();

    // No suppression and no forward decision.
    set_registers(8'd0, 8'd0);
    add_random(250);
    wait_drained();

    // Everything but full scale suppressed, always forward.
    set_registers(8'd255, 8'd255);
    add_random(150);
    wait_drained();

    set_registers(8'd0, 8'd181);
    add_random(200);
    wait_drained();

    set_registers(THRESHOLD_RESET, 8'd180);
    add_random(250);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      set_registers(8'($urandom_range(0, 60)), 8'($urandom_range(0, 180)));
      add_random(250);
      wait_drained();
    end

    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (steer_q.size() != 0) report_mismatch("results never returned", 0, steer_q.size());
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
